@@ rtl/core/drr_pkg.sv @@
// ----------------------------------------------------------------------------
// drr_pkg: shared types and constants for the descent reference ramp
// Field widths, phase and status codes, register indexes and the structs
// passed between the configuration block, the step logic and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package drr_pkg;

	localparam int HEIGHT_W  = 24;
	localparam int SHEIGHT_W = 25;
	localparam int RATE_W    = 20;
	localparam int DT_W      = 20;
	localparam int PROD_W    = RATE_W + DT_W;
	localparam int FRAC_W    = 16;
	localparam int STATUS_W  = 3;
	localparam int PHASE_W   = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 24;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 56;

	localparam logic [HEIGHT_W-1:0] ENTRY_RST   = 24'd65536;
	localparam logic [RATE_W-1:0]   RATE_RST    = 20'd13107;
	localparam logic [HEIGHT_W-1:0] MIN_RST     = 24'd6554;
	localparam logic [HEIGHT_W-1:0] MAX_ERR_RST = 24'd19661;

	typedef enum logic {
		OP_UPDATE = 1'b0,
		OP_CLEAR  = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		TD_NONE         = 3'd0,
		TD_CANDIDATE    = 3'd1,
		TD_CONFIRMED    = 3'd2,
		TD_REJECTED     = 3'd3,
		TD_INSUFFICIENT = 3'd4
	} td_status_t;

	typedef enum logic [PHASE_W-1:0] {
		PH_WAITING  = 3'd0,
		PH_PAUSED   = 3'd1,
		PH_TOUCHDOWN = 3'd2,
		PH_RECOVERY = 3'd3,
		PH_CANDIDATE = 3'd4,
		PH_DESCEND  = 3'd5
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENTRY_HEIGHT = 2'd0,
		CFG_DESCENT_RATE = 2'd1,
		CFG_MIN_HEIGHT   = 2'd2,
		CFG_MAX_TRK_ERR  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [HEIGHT_W-1:0] entry_height;
		logic [RATE_W-1:0]   descent_rate;
		logic [HEIGHT_W-1:0] minimum_height;
		logic [HEIGHT_W-1:0] max_tracking_error;
	} cfg_t;

	typedef struct packed {
		logic                 op;
		logic                 reference_valid;
		logic [SHEIGHT_W-1:0] measured_height;
		logic [SHEIGHT_W-1:0] seed_height;
		logic [DT_W-1:0]      time_step;
		logic                 authorized;
		logic                 window_open;
		logic [STATUS_W-1:0]  td_status;
	} item_t;

	typedef struct packed {
		logic [HEIGHT_W-1:0] ref_height;
		logic                seeded;
		logic                td_latched;
	} ramp_state_t;

	typedef struct packed {
		logic [HEIGHT_W-1:0] height_reference;
		logic [RATE_W-1:0]   descent_velocity;
		phase_t              phase;
		logic                ref_moved;
		logic                candidate_hold;
		logic                confirmed_hold;
		logic                recovery_request;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/core/drr_cfg.sv @@
// ----------------------------------------------------------------------------
// drr_cfg: configuration register bank
// Four registers written through the index/data channel, reset to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module drr_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [drr_pkg::CFG_IDX_W-1:0] wr_index,
	input  wire logic [drr_pkg::CFG_DATA_W-1:0] wr_data,
	output drr_pkg::cfg_t                      cfg
);
	import drr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.entry_height       <= ENTRY_RST;
			cfg_q.descent_rate       <= RATE_RST;
			cfg_q.minimum_height     <= MIN_RST;
			cfg_q.max_tracking_error <= MAX_ERR_RST;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				CFG_ENTRY_HEIGHT: cfg_q.entry_height       <= wr_data[HEIGHT_W-1:0];
				CFG_DESCENT_RATE: cfg_q.descent_rate       <= wr_data[RATE_W-1:0];
				CFG_MIN_HEIGHT:   cfg_q.minimum_height     <= wr_data[HEIGHT_W-1:0];
				CFG_MAX_TRK_ERR:  cfg_q.max_tracking_error <= wr_data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ rtl/core/drr_step.sv @@
// ----------------------------------------------------------------------------
// drr_step: single-item update logic
// Clears the state, or decides the phase in priority order, seeds or ramps
// the reference, and forms the result and next state for one registered item.
// ----------------------------------------------------------------------------
`default_nettype none

module drr_step (
	input  wire drr_pkg::item_t       item,
	input  wire drr_pkg::cfg_t        cfg,
	input  wire drr_pkg::ramp_state_t cur,
	output drr_pkg::ramp_state_t      nxt,
	output logic                      emit,
	output drr_pkg::result_t          res
);
	import drr_pkg::*;

	logic [HEIGHT_W-1:0] meas;
	logic [HEIGHT_W-1:0] seed;
	logic [HEIGHT_W-1:0] seed_clamped;
	logic [HEIGHT_W-1:0] err;
	logic [HEIGHT_W-1:0] room;
	logic [HEIGHT_W-1:0] dec;
	logic [PROD_W-1:0]   prod;
	logic                in_ok;
	logic                seed_step;
	phase_t              phase;
	logic [RATE_W-1:0]   vel;

	assign meas = item.measured_height[HEIGHT_W-1:0];
	assign seed = item.seed_height[HEIGHT_W-1:0];

	// negative heights (sign bit set) and a zero step are dropped
	assign in_ok = item.reference_valid && !item.measured_height[SHEIGHT_W-1]
		&& !item.seed_height[SHEIGHT_W-1] && (item.time_step != '0);

	// if the clamps cross, seeds under the floor get it, others the entry
	assign seed_clamped = (seed < cfg.minimum_height) ? cfg.minimum_height :
		(seed > cfg.entry_height) ? cfg.entry_height : seed;

	assign err  = (meas >= cur.ref_height) ? (meas - cur.ref_height) : (cur.ref_height - meas);
	assign prod = PROD_W'(cfg.descent_rate) * PROD_W'(item.time_step);
	assign dec  = prod[PROD_W-1:FRAC_W];
	assign room = cur.ref_height - cfg.minimum_height;

	always_comb begin
		nxt       = cur;
		emit      = 1'b0;
		seed_step = 1'b0;
		phase     = PH_WAITING;
		vel       = '0;
		if (op_t'(item.op) == OP_CLEAR) begin
			nxt = '0;
		end else if (in_ok) begin
			emit = 1'b1;
			if (!cur.seeded) begin
				seed_step      = 1'b1;
				nxt.ref_height = seed_clamped;
				nxt.seeded     = 1'b1;
				phase          = item.authorized ? PH_PAUSED : PH_WAITING;
			end else if (cur.td_latched || item.td_status == TD_CONFIRMED) begin
				nxt.td_latched = 1'b1;
				phase          = PH_TOUCHDOWN;
			end else if (item.td_status == TD_REJECTED) begin
				phase = PH_RECOVERY;
			end else if (item.td_status == TD_CANDIDATE) begin
				phase = PH_CANDIDATE;
			end else if (!item.authorized) begin
				phase = PH_WAITING;
			end else if (!item.window_open || item.td_status == TD_INSUFFICIENT) begin
				phase = PH_PAUSED;
			end else if (err > cfg.max_tracking_error) begin
				phase = PH_PAUSED;
			end else if (cur.ref_height <= cfg.minimum_height) begin
				nxt.ref_height = cfg.minimum_height;
				phase          = PH_PAUSED;
			end else begin
				nxt.ref_height = (dec >= room) ? cfg.minimum_height : (cur.ref_height - dec);
				phase          = PH_DESCEND;
				vel            = (dec != '0) ? cfg.descent_rate : '0;
			end
		end
	end

	always_comb begin
		res.height_reference  = nxt.ref_height;
		res.descent_velocity  = vel;
		res.phase             = phase;
		res.ref_moved         = !seed_step && (nxt.ref_height != cur.ref_height);
		res.candidate_hold    = (phase == PH_CANDIDATE);
		res.confirmed_hold    = (phase == PH_TOUCHDOWN);
		res.recovery_request  = (phase == PH_RECOVERY);
	end

endmodule

`default_nettype wire

@@ rtl/core/descent_reference_ramp_core.sv @@
// ----------------------------------------------------------------------------
// descent_reference_ramp_core: final-descent height reference ramp
// Input register, combinational update logic and an output register.
// ----------------------------------------------------------------------------
// Path: an item is captured in the input register, passes the 20x20 multiply
//   and compare, and its result is held in the output register for m_axis.
// Throughput: one item per cycle unless the receiver stalls the output; the
//   ramp state updates in the same cycle the item leaves the input register.
// Reset: arst_n clears the ramp state and both stages; registers take defaults.
`default_nettype none

module descent_reference_ramp_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// [0] reference_valid, [25:1] measured_height, [50:26] seed_height,
	// [70:51] time_step, [71] authorized, [72] window_open,
	// [75:73] td_status, [79:76] zero
	input  wire logic [drr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// [0] op
	input  wire logic                           s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// [23:0] height_reference, [43:24] descent_velocity, [46:44] phase,
	// [47] ref_moved, [48] candidate_hold, [49] confirmed_hold,
	// [50] recovery_request, [55:51] zero
	output logic [drr_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [drr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [drr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import drr_pkg::*;

	cfg_t        cfg;
	item_t       item_s1;
	logic        valid_s1;
	ramp_state_t state_q;
	ramp_state_t state_nxt;
	logic        emit;
	result_t     res;
	result_t     res_q;
	logic        out_valid_q;
	logic        advance;
	logic        in_xfer;

	assign cfg_ready = 1'b1;

	drr_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	drr_step u_step (
		.item (item_s1),
		.cfg  (cfg),
		.cur  (state_q),
		.nxt  (state_nxt),
		.emit (emit),
		.res  (res)
	);

	// items that give no result never wait for the output register
	assign advance       = valid_s1 && (!emit || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.op               <= s_axis_tuser;
			item_s1.reference_valid  <= s_axis_tdata[0];
			item_s1.measured_height  <= s_axis_tdata[25:1];
			item_s1.seed_height      <= s_axis_tdata[50:26];
			item_s1.time_step        <= s_axis_tdata[70:51];
			item_s1.authorized       <= s_axis_tdata[71];
			item_s1.window_open      <= s_axis_tdata[72];
			item_s1.td_status        <= s_axis_tdata[75:73];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, res_q.recovery_request, res_q.confirmed_hold,
		res_q.candidate_hold, res_q.ref_moved, res_q.phase,
		res_q.descent_velocity, res_q.height_reference};

	a_latch_needs_seed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.td_latched |-> state_q.seeded)
		else $error("touchdown latched while unseeded");

	a_stalled_item_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("stalled input stage lost its item");

	a_velocity_only_descending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.descent_velocity != '0) |-> (res_q.phase == PH_DESCEND))
		else $error("velocity reported outside descent");

	a_change_only_moving: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.ref_moved
		|-> (res_q.phase == PH_DESCEND) || (res_q.phase == PH_PAUSED))
		else $error("reference moved in a holding phase");

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: regression for the descent reference ramp core
// Streams update and clear steps into the core under random sender gaps and
// receiver stalls. A tracker class follows the ramp state and register
// settings, queues the reference, velocity and phase each accepted step
// should produce, and checks every result transfer against them.
// ----------------------------------------------------------------------------

module testbench;

	import drr_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 6;
	localparam int PHASE_ITEMS    = 130;
	localparam logic [STATUS_W-1:0] TD_UNKNOWN = 3'd7;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_t;

	// Follows the ramp state and settings, holds the results still owed.
	class ramp_tracker;
		logic [HEIGHT_W-1:0] entry_h, floor_h, trk_lim, ref_h;
		logic [RATE_W-1:0]   rate;
		bit                  seeded, latched;
		result_t             pending_refs[$];
		int                  errors, updates, clears, results, reg_writes;
		int                  phase_seen[6];

		function new();
			entry_h = ENTRY_RST;
			rate    = RATE_RST;
			floor_h = MIN_RST;
			trk_lim = MAX_ERR_RST;
			wipe();
		endfunction

		function void wipe();
			ref_h   = '0;
			seeded  = 1'b0;
			latched = 1'b0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
			reg_writes++;
			case (idx)
				CFG_ENTRY_HEIGHT: entry_h = v;
				CFG_DESCENT_RATE: rate    = v[RATE_W-1:0];
				CFG_MIN_HEIGHT:   floor_h = v;
				CFG_MAX_TRK_ERR:  trk_lim = v;
			endcase
		endfunction

		function void post(logic [HEIGHT_W-1:0] prior, logic [RATE_W-1:0] vel, phase_t ph);
			result_t r;
			r.height_reference  = ref_h;
			r.descent_velocity  = vel;
			r.phase             = ph;
			r.ref_moved         = (ref_h != prior);
			r.candidate_hold    = (ph == PH_CANDIDATE);
			r.confirmed_hold    = (ph == PH_TOUCHDOWN);
			r.recovery_request  = (ph == PH_RECOVERY);
			pending_refs.push_back(r);
		endfunction

		function void take_update(item_t it);
			logic [HEIGHT_W-1:0] prior, meas, gap, dec, room;
			logic [PROD_W-1:0]   prod;
			if (it.op == OP_CLEAR) begin
				clears++;
				wipe();
				return;
			end
			if (!it.reference_valid || it.measured_height[SHEIGHT_W-1] ||
			    it.seed_height[SHEIGHT_W-1] || it.time_step == '0)
				return;
			updates++;
			prior = ref_h;
			if (!seeded) begin
				// floor is tested first; above entry, it wins only for seeds below it
				ref_h = it.seed_height[HEIGHT_W-1:0];
				if (ref_h < floor_h)
					ref_h = floor_h;
				else if (ref_h > entry_h)
					ref_h = entry_h;
				seeded = 1'b1;
				if (it.authorized)
					post(ref_h, '0, PH_PAUSED);
				else
					post(ref_h, '0, PH_WAITING);
				return;
			end
			if (latched || it.td_status == TD_CONFIRMED) begin
				latched = 1'b1;
				post(prior, '0, PH_TOUCHDOWN);
				return;
			end
			if (it.td_status == TD_REJECTED) begin
				post(prior, '0, PH_RECOVERY);
				return;
			end
			if (it.td_status == TD_CANDIDATE) begin
				post(prior, '0, PH_CANDIDATE);
				return;
			end
			if (!it.authorized) begin
				post(prior, '0, PH_WAITING);
				return;
			end
			if (!it.window_open || it.td_status == TD_INSUFFICIENT) begin
				post(prior, '0, PH_PAUSED);
				return;
			end
			meas = it.measured_height[HEIGHT_W-1:0];
			gap  = (meas > ref_h) ? meas - ref_h : ref_h - meas;
			if (gap > trk_lim) begin
				post(prior, '0, PH_PAUSED);
				return;
			end
			if (ref_h <= floor_h) begin
				ref_h = floor_h;
				post(prior, '0, PH_PAUSED);
				return;
			end
			// Q4.16 x Q4.16, truncated back to Q8.16
			prod  = PROD_W'(rate) * PROD_W'(it.time_step);
			dec   = prod[PROD_W-1:FRAC_W];
			room  = ref_h - floor_h;
			ref_h = (dec >= room) ? floor_h : ref_h - dec;
			post(prior, (ref_h < prior) ? rate : '0, PH_DESCEND);
		endfunction

		function void compare(string what, logic [HEIGHT_W-1:0] want,
		                      logic [HEIGHT_W-1:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
			end
		endfunction

		function void check_output(logic [OUT_DATA_W-1:0] d);
			result_t want;
			results++;
			if (pending_refs.size() == 0) begin
				errors++;
				$display("%0t: result transfer %h with nothing expected", $time, d);
				return;
			end
			want = pending_refs.pop_front();
			phase_seen[want.phase]++;
			compare("height_reference", want.height_reference, d[23:0]);
			compare("descent_velocity", want.descent_velocity, d[43:24]);
			compare("phase", want.phase, d[46:44]);
			compare("ref_moved", want.ref_moved, d[47]);
			compare("candidate_hold", want.candidate_hold, d[48]);
			compare("confirmed_hold", want.confirmed_hold, d[49]);
			compare("recovery_request", want.recovery_request, d[50]);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid, s_axis_tready, s_axis_tuser;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid, m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ramp_tracker tracker;
	item_t       seen_item;
	int          quiet_cycles = 0;
	int          burst_left = 0;
	int          stall_run = 0;
	rx_mode_t    stall_mode = RX_OPEN;

	descent_reference_ramp_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// receiver back-pressure, switching between a few stall patterns
	always @(negedge clk) begin
		if (stall_run == 0) begin
			stall_mode = rx_mode_t'($urandom_range(0, 3));
			stall_run  = $urandom_range(8, 64);
		end else begin
			stall_run--;
		end
		case (stall_mode)
			RX_OPEN:   m_axis_tready <= 1'b1;
			RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE: m_axis_tready <= ($urandom_range(0, 5) == 0);
			default:   m_axis_tready <= (stall_run[1:0] != 2'b00);
		endcase
	end

	// transfer monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				seen_item.op               = s_axis_tuser;
				seen_item.reference_valid  = s_axis_tdata[0];
				seen_item.measured_height  = s_axis_tdata[25:1];
				seen_item.seed_height      = s_axis_tdata[50:26];
				seen_item.time_step        = s_axis_tdata[70:51];
				seen_item.authorized       = s_axis_tdata[71];
				seen_item.window_open      = s_axis_tdata[72];
				seen_item.td_status        = s_axis_tdata[75:73];
				tracker.take_update(seen_item);
			end
			if (m_axis_tvalid && m_axis_tready)
				tracker.check_output(m_axis_tdata);
			if (cfg_valid && cfg_ready)
				tracker.set_reg(cfg_idx_t'(cfg_index), cfg_data);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			    (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d results outstanding",
				         $time, quiet_cycles, tracker.pending_refs.size());
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	function automatic logic [SHEIGHT_W-1:0] on_ref();
		return {1'b0, tracker.ref_h};
	endfunction

	function automatic item_t update_item(logic valid, logic [SHEIGHT_W-1:0] meas,
	                                      logic [SHEIGHT_W-1:0] seed, logic [DT_W-1:0] dt,
	                                      logic auth, logic win,
	                                      logic [STATUS_W-1:0] status);
		item_t it;
		it.op               = OP_UPDATE;
		it.reference_valid  = valid;
		it.measured_height  = meas;
		it.seed_height      = seed;
		it.time_step        = dt;
		it.authorized       = auth;
		it.window_open      = win;
		it.td_status        = status;
		return it;
	endfunction

	function automatic item_t clear_item();
		logic [95:0] raw;
		item_t       it;
		raw   = {$urandom, $urandom, $urandom};
		it    = raw[$bits(item_t)-1:0];
		it.op = OP_CLEAR;
		return it;
	endfunction

	// Mostly well-formed steps tracking the reference, plus noise and faults.
	function automatic item_t random_item();
		logic [95:0] raw;
		item_t       it;
		int          pick, kind, span, off;
		longint      m;
		raw  = {$urandom, $urandom, $urandom};
		it   = raw[$bits(item_t)-1:0];
		pick = $urandom_range(0, 99);
		if (pick < 4)
			return clear_item();
		if (pick < 14)
			return it;
		it.op              = OP_UPDATE;
		it.reference_valid = 1'b1;
		it.authorized      = ($urandom_range(0, 11) != 0);
		it.window_open     = ($urandom_range(0, 11) != 0);
		kind = $urandom_range(0, 99);
		if (kind < 70)
			it.td_status = TD_NONE;
		else if (kind < 78)
			it.td_status = TD_CANDIDATE;
		else if (kind < 84)
			it.td_status = TD_REJECTED;
		else if (kind < 90)
			it.td_status = TD_INSUFFICIENT;
		else if (kind < 92)
			it.td_status = TD_CONFIRMED;
		else
			it.td_status = 3'($urandom_range(5, 7));
		span = int'(tracker.trk_lim);
		if (span > 'h80000)
			span = 'h80000;
		if ($urandom_range(0, 9) == 0)
			span = span * 4 + 16;
		off = int'($urandom_range(0, 2 * span)) - span;
		m   = longint'(tracker.ref_h) + off;
		if (m < 0)
			m = 0;
		else if (m > 'hFFFFFF)
			m = 'hFFFFFF;
		it.measured_height = m[SHEIGHT_W-1:0];
		if ($urandom_range(0, 1))
			it.seed_height = {1'b0, 24'($urandom)};
		else
			it.seed_height = {1'b0, 24'($urandom_range(tracker.floor_h, tracker.entry_h))};
		kind = $urandom_range(0, 9);
		if (kind < 6)
			it.time_step = 20'($urandom_range(1, 'hFFF));
		else if (kind < 9)
			it.time_step = 20'($urandom_range(1, 'hFFFF));
		else
			it.time_step = 20'($urandom_range(1, 'hFFFFF));
		if (pick < 20) begin
			case ($urandom_range(0, 3))
				0:       it.reference_valid = 1'b0;
				1:       it.measured_height[SHEIGHT_W-1] = 1'b1;
				2:       it.seed_height[SHEIGHT_W-1] = 1'b1;
				default: it.time_step = '0;
			endcase
		end
		return it;
	endfunction

	// called just after a falling edge; returns at the falling edge after the transfer
	task automatic push(item_t it);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= it.op;
		s_axis_tdata  <= {4'b0, it.td_status, it.window_open, it.authorized,
		                  it.time_step, it.seed_height, it.measured_height,
		                  it.reference_valid};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic send(item_t it);
		int idle;
		if (burst_left == 0) begin
			idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (idle > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (idle) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		push(it);
	endtask

	// hold off until every owed result is back, then let the pipeline empty
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (tracker.pending_refs.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic load_settings(logic [HEIGHT_W-1:0] entry, logic [RATE_W-1:0] speed,
	                             logic [HEIGHT_W-1:0] floor_v, logic [HEIGHT_W-1:0] trk);
		write_reg(CFG_ENTRY_HEIGHT, entry);
		write_reg(CFG_DESCENT_RATE, {4'b0, speed});
		write_reg(CFG_MIN_HEIGHT, floor_v);
		write_reg(CFG_MAX_TRK_ERR, trk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int                  setting, n;
		logic [HEIGHT_W-1:0] entry, floor_v;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser  = 1'b0;
		s_axis_tdata  = '0;
		cfg_valid     = 1'b0;
		cfg_index     = CFG_ENTRY_HEIGHT;
		cfg_data      = '0;
		tracker       = new();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed steps on the reset settings
		send(clear_item());
		send(update_item(1'b0, 25'd65536, 25'd65536, 20'd100, 1'b1, 1'b1, TD_NONE));
		send(update_item(1'b1, 25'h1000000, 25'd65536, 20'd100, 1'b1, 1'b1, TD_NONE));
		send(update_item(1'b1, 25'd65536, 25'h1FFFFFF, 20'd100, 1'b1, 1'b1, TD_NONE));
		send(update_item(1'b1, 25'd65536, 25'd65536, 20'd0, 1'b1, 1'b1, TD_NONE));
		// seed under the floor, then over entry with a status that seeding ignores
		send(update_item(1'b1, 25'd0, 25'd100, 20'hFFFFF, 1'b1, 1'b0, TD_NONE));
		send(clear_item());
		send(update_item(1'b1, 25'hFFFFFF, 25'hFFFFFF, 20'd1, 1'b0, 1'b1, TD_CONFIRMED));
		// unknown status counts as none; tiny dt gives a zero decrement
		send(update_item(1'b1, on_ref(), 25'd0, 20'd1, 1'b1, 1'b1, TD_UNKNOWN));
		send(update_item(1'b1, on_ref(), 25'd0, 20'h10000, 1'b1, 1'b1, TD_NONE));
		send(update_item(1'b1, on_ref(), 25'd0, 20'h100, 1'b1, 1'b1, TD_CANDIDATE));
		send(update_item(1'b1, on_ref(), 25'd0, 20'h100, 1'b1, 1'b1, TD_REJECTED));
		send(update_item(1'b1, on_ref(), 25'd0, 20'h100, 1'b0, 1'b1, TD_NONE));
		send(update_item(1'b1, on_ref(), 25'd0, 20'h100, 1'b1, 1'b0, TD_NONE));
		send(update_item(1'b1, on_ref(), 25'd0, 20'h100, 1'b1, 1'b1, TD_INSUFFICIENT));
		// tracking error right at the limit ramps, one above pauses
		send(update_item(1'b1, on_ref() + {1'b0, tracker.trk_lim}, 25'd0, 20'h100,
		                 1'b1, 1'b1, TD_NONE));
		send(update_item(1'b1, on_ref() + {1'b0, tracker.trk_lim} + 25'd1, 25'd0, 20'h100,
		                 1'b1, 1'b1, TD_NONE));
		send(update_item(1'b1, 25'hFFFFFF, 25'd0, 20'h100, 1'b1, 1'b1, TD_NONE));
		// big step lands on the floor, next one pauses there
		send(update_item(1'b1, on_ref(), 25'd0, 20'hFFFFF, 1'b1, 1'b1, TD_NONE));
		send(update_item(1'b1, on_ref(), 25'd0, 20'hFFFFF, 1'b1, 1'b1, TD_NONE));
		// confirmed touchdown latches until a clear
		send(update_item(1'b1, on_ref(), 25'd0, 20'h100, 1'b1, 1'b1, TD_CONFIRMED));
		send(update_item(1'b1, on_ref(), 25'd0, 20'h100, 1'b1, 1'b1, TD_NONE));
		send(clear_item());
		send(update_item(1'b1, 25'd10000, 25'd10000, 20'h100, 1'b1, 1'b1, TD_NONE));
		// floor raised above the held reference: next update snaps up to it
		drain();
		write_reg(CFG_MIN_HEIGHT, 24'd40000);
		cfg_valid <= 1'b0;
		send(update_item(1'b1, on_ref(), 25'd0, 20'h100, 1'b1, 1'b1, TD_NONE));

		for (setting = 0; setting < 5; setting++) begin
			drain();
			case (setting)
				0: load_settings(24'hFFFFFF, 20'hFFFFF, 24'd1, 24'hFFFFFF);
				1: load_settings(24'd1, 20'd1, 24'hFFFFFF, 24'd1);
				2: begin
					entry   = 24'($urandom_range('h20000, 'hFFFFFF));
					floor_v = 24'($urandom_range(1, (entry >> 2) + 1));
					load_settings(entry, 20'($urandom_range(1, 'h40000)), floor_v,
					              24'($urandom_range('h100, 'h80000)));
				end
				3: begin
					// floor above entry
					entry   = 24'($urandom_range(1, 'h10000));
					floor_v = 24'($urandom_range(entry + 1, 'h40000));
					load_settings(entry, 20'($urandom_range(1, 'h40000)), floor_v,
					              24'($urandom_range('h100, 'h80000)));
				end
				default: load_settings(ENTRY_RST, RATE_RST, MIN_RST, MAX_ERR_RST);
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				send(random_item());
				if (n == PHASE_ITEMS / 2)
					drain();
			end
		end
		drain();

		$display("covered %0d update steps and %0d clears, %0d results checked, %0d register writes",
		         tracker.updates, tracker.clears, tracker.results, tracker.reg_writes);
		$display("phases: wait %0d pause %0d hold %0d recovery %0d candidate %0d descend %0d",
		         tracker.phase_seen[0], tracker.phase_seen[1], tracker.phase_seen[2],
		         tracker.phase_seen[3], tracker.phase_seen[4], tracker.phase_seen[5]);
		if (tracker.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/drr_pkg.sv
rtl/core/drr_cfg.sv
rtl/core/drr_step.sv
rtl/core/descent_reference_ramp_core.sv
bench/testbench.sv
